// ===== rtl/uat_pkg.sv =====
// Shared types and constants of the undirected adjacency table.
`timescale 1ns / 1ps

package uat_pkg;

	localparam int COMMAND_W = 3;
	localparam int VERTEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int ANSWER_W = 5;

	// vertex numbers that a command can name at all
	localparam int VERTEX_SPAN = 1 << VERTEX_W;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_ADD_EDGE    = 3'd0,
		CMD_DELETE_EDGE = 3'd1,
		CMD_DISCONNECT  = 3'd2,
		CMD_MAX_DEGREE  = 3'd3,
		CMD_ADJACENT    = 3'd4,
		CMD_TWO_PATH    = 3'd5
	} command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_A,
		ST_ROW_A,
		ST_READ_B,
		ST_ROW_B,
		ST_SWEEP,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/uat_if.sv =====
// Channel interfaces of the undirected adjacency table: request, response, configuration.
`timescale 1ns / 1ps

interface uat_request_if;
	logic                         valid;
	logic                         ready;
	logic [uat_pkg::COMMAND_W-1:0] command;
	logic [uat_pkg::VERTEX_W-1:0]  first_vertex;
	logic [uat_pkg::VERTEX_W-1:0]  second_vertex;

	modport source (output valid, command, first_vertex, second_vertex, input ready);
	modport sink (input valid, command, first_vertex, second_vertex, output ready);
endinterface

interface uat_response_if;
	logic                         valid;
	logic                         ready;
	logic [uat_pkg::ANSWER_W-1:0] answer;
	logic                         status;

	modport source (output valid, answer, status, input ready);
	modport sink (input valid, answer, status, output ready);
endinterface

interface uat_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [uat_pkg::COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/uat_row_mem.sv =====
// Adjacency row memory: one write port, one registered read port, per-row valid bits.
`timescale 1ns / 1ps

module uat_row_mem #(
	parameter int ROWS = 16,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [ROWS-1:0] wdata,
	input  logic [AW-1:0]   raddr,
	output logic [ROWS-1:0] rdata
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] valid_q;
	logic [ROWS-1:0] rd_data_q;
	logic            rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= valid_q[raddr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// a row never written reads as empty
	assign rdata = rd_ok_q ? rd_data_q : '0;

endmodule

// ===== rtl/undirected_adjacency_table.sv =====
// Top level of the undirected adjacency table: sequencer, row datapath and result register.
//
//  channel   | dir | handshake        | word
//  ----------+-----+------------------+----------------------------------------
//  cfg       | in  | valid / ready    | data: vertex_count (5 b)
//  request   | in  | valid / ready    | command (3 b), first_vertex, second_vertex
//  response  | out | valid / ready    | answer (5 b), status (1 b)
//
// Add, delete and two-path read row a, then row b; adjacent reads row a only;
// disconnect walks all NV stored rows and max degree min(vertex_count, NV) rows;
// an out-of-range operand or unknown command goes straight to the finish state
// (NV = min(MAX_VERTICES, 16)). The row memory has one read port: one row per cycle.
// Request ready is high only while the sequencer is idle; a finished result
// waits in the response register while the next request is taken.
// Reset clears per-row valid bits at once, so no clearing pass is needed.
// Configuration writes are always taken (cfg.ready is tied high).
`timescale 1ns / 1ps

module undirected_adjacency_table #(
	parameter int MAX_VERTICES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	uat_cfg_if.sink      cfg,
	uat_request_if.sink  request,
	uat_response_if.source response
);

	// Vertices beyond the 4-bit vertex fields can never hold an edge, so the
	// store keeps only the rows and columns that commands can name.
	localparam int NV = (MAX_VERTICES < uat_pkg::VERTEX_SPAN) ? MAX_VERTICES
	                                                          : uat_pkg::VERTEX_SPAN;
	localparam int AW = $clog2(NV);
	localparam int CAP = (MAX_VERTICES < uat_pkg::COUNT_MAX) ? MAX_VERTICES
	                                                         : uat_pkg::COUNT_MAX;
	localparam int CW = uat_pkg::COUNT_W;
	localparam int ANW = uat_pkg::ANSWER_W;

	uat_pkg::state_t state_q, state_d;

	logic [CW-1:0]                  count_q;
	logic [uat_pkg::COMMAND_W-1:0]  cmd_q;
	logic [AW-1:0]                  a_q, b_q;
	logic [NV-1:0]                  hold_q;
	logic [CW-1:0]                  k_q;
	logic                           pend_q;
	logic [AW-1:0]                  pend_idx_q;
	logic [ANW-1:0]                 ans_q;
	logic                           stat_q;

	logic                           out_valid_q;
	logic [ANW-1:0]                 out_answer_q;
	logic                           out_status_q;

	logic [CW-1:0]   eff_count;
	logic [CW-1:0]   sweep_lim;
	logic [NV-1:0]   col_mask;
	logic [NV-1:0]   row;
	logic [ANW-1:0]  row_deg;
	logic            a_ok, b_ok, req_err;
	logic            in_ready;
	logic            accept;
	logic            finish_fire;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [NV-1:0]   mem_wdata;
	logic [AW-1:0]   mem_raddr;

	uat_row_mem #(
		.ROWS (NV),
		.AW   (AW)
	) u_rows (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (row)
	);

	// Clamp the configured count to capacity.
	assign eff_count = (count_q > CW'(CAP)) ? CW'(CAP) : count_q;

	// Only columns of vertices in use count toward degree and shared neighbors.
	always_comb begin
		for (int c = 0; c < NV; c++) begin
			col_mask[c] = (CW'(c) < eff_count);
		end
	end

	assign row_deg = ANW'($countones(row & col_mask));

	// Disconnect walks every stored row; max degree walks rows in use.
	assign sweep_lim = (cmd_q == uat_pkg::CMD_DISCONNECT) ? CW'(NV)
	                 : ((eff_count > CW'(NV)) ? CW'(NV) : eff_count);

	// Range check on the incoming word.
	assign a_ok = ({1'b0, request.first_vertex} < eff_count);
	assign b_ok = ({1'b0, request.second_vertex} < eff_count);

	always_comb begin
		unique case (request.command)
			uat_pkg::CMD_ADD_EDGE,
			uat_pkg::CMD_DELETE_EDGE,
			uat_pkg::CMD_ADJACENT,
			uat_pkg::CMD_TWO_PATH:   req_err = !(a_ok && b_ok);
			uat_pkg::CMD_DISCONNECT: req_err = !a_ok;
			default:                 req_err = 1'b0;
		endcase
	end

	assign accept = request.valid && in_ready;
	assign finish_fire = (state_q == uat_pkg::ST_FINISH) && (!out_valid_q || response.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uat_pkg::ST_IDLE: begin
				if (request.valid) begin
					if (req_err) begin
						state_d = uat_pkg::ST_FINISH;
					end else begin
						unique case (request.command)
							uat_pkg::CMD_ADD_EDGE,
							uat_pkg::CMD_DELETE_EDGE,
							uat_pkg::CMD_ADJACENT,
							uat_pkg::CMD_TWO_PATH:   state_d = uat_pkg::ST_READ_A;
							uat_pkg::CMD_DISCONNECT,
							uat_pkg::CMD_MAX_DEGREE: state_d = uat_pkg::ST_SWEEP;
							default:                 state_d = uat_pkg::ST_FINISH;
						endcase
					end
				end
			end
			uat_pkg::ST_READ_A: state_d = uat_pkg::ST_ROW_A;
			uat_pkg::ST_ROW_A: begin
				state_d = (cmd_q == uat_pkg::CMD_ADJACENT) ? uat_pkg::ST_FINISH
				                                           : uat_pkg::ST_READ_B;
			end
			uat_pkg::ST_READ_B: state_d = uat_pkg::ST_ROW_B;
			uat_pkg::ST_ROW_B:  state_d = uat_pkg::ST_FINISH;
			uat_pkg::ST_SWEEP: begin
				if (k_q >= sweep_lim) begin
					state_d = uat_pkg::ST_FINISH;
				end
			end
			uat_pkg::ST_FINISH: begin
				if (!out_valid_q || response.ready) begin
					state_d = uat_pkg::ST_IDLE;
				end
			end
			default: state_d = uat_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory port and request ready.
	always_comb begin
		in_ready  = 1'b0;
		mem_raddr = a_q;
		mem_we    = 1'b0;
		mem_waddr = a_q;
		mem_wdata = row;
		unique case (state_q)
			uat_pkg::ST_IDLE: in_ready = 1'b1;
			uat_pkg::ST_READ_A: mem_raddr = a_q;
			uat_pkg::ST_ROW_A: begin
				// set or clear bit b of row a
				mem_waddr = a_q;
				if (cmd_q == uat_pkg::CMD_ADD_EDGE) begin
					mem_we    = 1'b1;
					mem_wdata = row | (NV'(1) << b_q);
				end else if (cmd_q == uat_pkg::CMD_DELETE_EDGE) begin
					mem_we    = 1'b1;
					mem_wdata = row & ~(NV'(1) << b_q);
				end
			end
			uat_pkg::ST_READ_B: mem_raddr = b_q;
			uat_pkg::ST_ROW_B: begin
				// mirror bit: a of row b (row b was read after row a was written)
				mem_waddr = b_q;
				if (cmd_q == uat_pkg::CMD_ADD_EDGE) begin
					mem_we    = 1'b1;
					mem_wdata = row | (NV'(1) << a_q);
				end else if (cmd_q == uat_pkg::CMD_DELETE_EDGE) begin
					mem_we    = 1'b1;
					mem_wdata = row & ~(NV'(1) << a_q);
				end
			end
			uat_pkg::ST_SWEEP: begin
				// read row k while, for disconnect, the row read last cycle is written back
				mem_raddr = k_q[AW-1:0];
				mem_waddr = pend_idx_q;
				if (pend_q && (cmd_q == uat_pkg::CMD_DISCONNECT)) begin
					mem_we    = 1'b1;
					mem_wdata = (pend_idx_q == a_q) ? '0 : (row & ~(NV'(1) << a_q));
				end
			end
			uat_pkg::ST_FINISH: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	assign request.ready = in_ready;
	assign cfg.ready     = 1'b1;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uat_pkg::ST_IDLE;
			count_q     <= uat_pkg::COUNT_RESET;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				count_q <= cfg.data;
			end
			if (accept) begin
				k_q    <= '0;
				pend_q <= 1'b0;
			end else if (state_q == uat_pkg::ST_SWEEP) begin
				if (k_q < sweep_lim) begin
					k_q    <= k_q + CW'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (finish_fire) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= request.command;
			a_q    <= request.first_vertex[AW-1:0];
			b_q    <= request.second_vertex[AW-1:0];
			ans_q  <= '0;
			stat_q <= req_err ? uat_pkg::STATUS_RANGE : uat_pkg::STATUS_OK;
		end
		unique case (state_q)
			uat_pkg::ST_ROW_A: begin
				if (cmd_q == uat_pkg::CMD_ADJACENT) begin
					ans_q <= ANW'(row[b_q]);
				end
				hold_q <= row;
			end
			uat_pkg::ST_ROW_B: begin
				if (cmd_q == uat_pkg::CMD_TWO_PATH) begin
					// direct edge, or a common neighbor in use
					ans_q <= ANW'(hold_q[b_q] | (|(hold_q & row & col_mask)));
				end
			end
			uat_pkg::ST_SWEEP: begin
				pend_idx_q <= k_q[AW-1:0];
				if (pend_q && (cmd_q == uat_pkg::CMD_MAX_DEGREE) && (row_deg > ans_q)) begin
					ans_q <= row_deg;
				end
			end
			default: begin
			end
		endcase
		if (finish_fire) begin
			out_answer_q <= ans_q;
			out_status_q <= stat_q;
		end
	end

	assign response.valid  = out_valid_q;
	assign response.answer = out_answer_q;
	assign response.status = out_status_q;

endmodule

// ===== rtl/uat_checker.sv =====
// Port-level assertions for the undirected adjacency table and their bind.
`timescale 1ns / 1ps

module uat_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [uat_pkg::ANSWER_W-1:0] rsp_answer,
	input logic                         rsp_status
);

	// hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer) && $stable(rsp_status))
		else $error("response word changed while stalled");

	// an error result carries no answer
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == uat_pkg::STATUS_RANGE) |-> rsp_answer == '0)
		else $error("range error with nonzero answer");

	// one request at a time: drop ready right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a degree cannot exceed the vertex field span
	a_answer_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_answer <= uat_pkg::ANSWER_W'(uat_pkg::VERTEX_SPAN))
		else $error("answer above largest degree");

endmodule

bind undirected_adjacency_table uat_checker u_uat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (request.valid),
	.req_ready  (request.ready),
	.rsp_valid  (response.valid),
	.rsp_ready  (response.ready),
	.rsp_answer (response.answer),
	.rsp_status (response.status)
);
